>>> design/complex_arith_unit_macros.svh
// Assertion macros for the checker file.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/cau_pkg.sv
package cau_pkg;

   // Number format and limits
   localparam int FRAC_BITS = 16;
   localparam int MAX_POWER = 16;
   localparam int DW        = 32;
   localparam int EXP_W     = 6;
   localparam int MODE_W    = 3;
   localparam int STAT_W    = 2;

   // Port widths
   localparam int REQ_DATA_W = 136;
   localparam int REQ_USER_W = 8;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 8;

   // Datapath widths
   localparam int PROD_W    = 2 * DW;
   localparam int ACC_W     = PROD_W + 2;
   localparam int DEN_W     = PROD_W;
   localparam int DSH_W     = DEN_W + FRAC_BITS;
   localparam int DIV_STEPS = DSH_W;
   localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
   localparam int Q_W       = DW + 2;
   localparam int PCNT_W    = $clog2(MAX_POWER + 1);

   // Operation modes
   localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SUB = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DIV = 3'd3;
   localparam logic [MODE_W-1:0] MODE_POW = 3'd4;

   // Result status
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DZ   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVF  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RSVD = 2'd3;

   // Multiplier operand pairs
   localparam logic [2:0] MUL_XR_YR = 3'd0;
   localparam logic [2:0] MUL_XI_YI = 3'd1;
   localparam logic [2:0] MUL_XR_YI = 3'd2;
   localparam logic [2:0] MUL_XI_YR = 3'd3;
   localparam logic [2:0] MUL_YR_YR = 3'd4;
   localparam logic [2:0] MUL_YI_YI = 3'd5;

   // Accumulator operations
   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   // Constants
   localparam logic [DW-1:0] ONE_VAL = DW'(1) << FRAC_BITS;
   localparam logic [DW-1:0] MAX_VAL = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MIN_VAL = {1'b1, {(DW-1){1'b0}}};
   localparam logic [ACC_W:0] RND_POS = (ACC_W+1)'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_W:0] RND_NEG = RND_POS - (ACC_W+1)'(1);
   localparam logic [Q_W:0]   LIM_NEG = (Q_W+1)'(1) << (DW - 1);
   localparam logic [Q_W:0]   LIM_POS = LIM_NEG - (Q_W+1)'(1);

   // Controller to datapath commands
   typedef struct packed {
      logic       load;
      logic [2:0] mul_sel;
      logic [1:0] acc_op;
      logic       den_we;
      logic       div_init;
      logic       div_step;
      logic       wr_re;
      logic       wr_im;
      logic       from_div;
      logic       addsub_we;
      logic       addsub_sub;
      logic       set_one;
      logic       pow_init;
      logic       pow_neg;
      logic       x_from_res;
      logic       y_from_res;
      logic       set_dz;
      logic       out_load;
   } cau_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic acc_zero;
      logic out_busy;
   } cau_stat_type;

endpackage

>>> design/cau_datapath.sv
module cau_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  cau_pkg::cau_cmd_type          cmd,
   output cau_pkg::cau_stat_type         stat,
   input  logic [cau_pkg::DW-1:0]        a_re,
   input  logic [cau_pkg::DW-1:0]        a_im,
   input  logic [cau_pkg::DW-1:0]        b_re,
   input  logic [cau_pkg::DW-1:0]        b_im,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cau_pkg::RSP_DATA_W-1:0] rsp_tdata,  // res_re, res_im
   output logic [cau_pkg::RSP_USER_W-1:0] rsp_tuser   // status
);
   import cau_pkg::*;

   logic signed [DW-1:0] xr_ff, xr_in, xi_ff, xi_in, yr_ff, yr_in, yi_ff, yi_in;
   logic signed [DW-1:0] rr_ff, rr_in, ri_ff, ri_in;
   logic                 ovf_ff, ovf_in, dz_ff, dz_in;
   logic signed [DW-1:0] op_a, op_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, prod_ext;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DSH_W-1:0]     dsh_ff, dsh_in;
   logic [Q_W-1:0]       q_ff, q_in;
   logic                 big_ff, big_in, neg_ff, neg_in;
   logic [DW-1:0]        ore_ff, ore_in, oim_ff, oim_in;
   logic [STAT_W-1:0]    ost_ff, ost_in;
   logic                 ov_ff, ov_in;

   // Rounding of the accumulator
   logic [ACC_W:0]              rnd_sum;
   logic [ACC_W-FRAC_BITS:0]    rnd_q;
   logic [ACC_W-FRAC_BITS-DW+1:0] rnd_hi;
   logic                        mul_ovf;
   logic [DW-1:0]               mul_val;

   // Division
   logic [DEN_W:0]   dtry, dsub, rem2;
   logic             dge, rup;
   logic [Q_W:0]     qr;
   logic             div_ovf;
   logic [DW-1:0]    div_val;
   logic [ACC_W-1:0] acc_abs;

   // Add / subtract
   logic signed [DW:0] as_re, as_im;
   logic               as_re_ovf, as_im_ovf;
   logic [DW-1:0]      as_re_val, as_im_val;

   logic wr_ovf;

   // Shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_XR_YR: begin op_a = xr_ff; op_b = yr_ff; end
         MUL_XI_YI: begin op_a = xi_ff; op_b = yi_ff; end
         MUL_XR_YI: begin op_a = xr_ff; op_b = yi_ff; end
         MUL_XI_YR: begin op_a = xi_ff; op_b = yr_ff; end
         MUL_YR_YR: begin op_a = yr_ff; op_b = yr_ff; end
         MUL_YI_YI: begin op_a = yi_ff; op_b = yi_ff; end
         default:   begin op_a = '0;    op_b = '0;    end
      endcase
   end
   assign prod_in  = op_a * op_b;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // Accumulator
   always_comb begin
      unique case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ext;
         ACC_ADD:  acc_in = acc_ff + prod_ext;
         ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:  acc_in = acc_ff;
      endcase
   end

   // Round half away from zero, then saturate
   always_comb begin
      rnd_sum = {acc_ff[ACC_W-1], acc_ff} + (acc_ff[ACC_W-1] ? RND_NEG : RND_POS);
      rnd_q   = rnd_sum[ACC_W:FRAC_BITS];
      rnd_hi  = rnd_q[ACC_W-FRAC_BITS:DW-1];
      mul_ovf = !((&rnd_hi) || !(|rnd_hi));
      mul_val = mul_ovf ? (rnd_sum[ACC_W] ? MIN_VAL : MAX_VAL) : rnd_q[DW-1:0];
   end

   // Restoring divider step and final rounding
   always_comb begin
      dtry    = {rem_ff, dsh_ff[DSH_W-1]};
      dsub    = dtry - {1'b0, den_ff};
      dge     = dtry >= {1'b0, den_ff};
      rem2    = {rem_ff, 1'b0};
      rup     = rem2 >= {1'b0, den_ff};
      qr      = {1'b0, q_ff} + (Q_W+1)'(rup);
      div_ovf = big_ff || (neg_ff ? (qr > LIM_NEG) : (qr > LIM_POS));
      div_val = div_ovf ? (neg_ff ? MIN_VAL : MAX_VAL)
                        : (neg_ff ? -qr[DW-1:0] : qr[DW-1:0]);
      acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   end

   // Saturating add / subtract
   always_comb begin
      as_re     = cmd.addsub_sub ? (xr_ff - yr_ff) : (xr_ff + yr_ff);
      as_im     = cmd.addsub_sub ? (xi_ff - yi_ff) : (xi_ff + yi_ff);
      as_re_ovf = as_re[DW] != as_re[DW-1];
      as_im_ovf = as_im[DW] != as_im[DW-1];
      as_re_val = as_re_ovf ? (as_re[DW] ? MIN_VAL : MAX_VAL) : as_re[DW-1:0];
      as_im_val = as_im_ovf ? (as_im[DW] ? MIN_VAL : MAX_VAL) : as_im[DW-1:0];
   end

   // Operand and result registers
   always_comb begin
      xr_in  = xr_ff;  xi_in = xi_ff;  yr_in = yr_ff;  yi_in = yi_ff;
      rr_in  = rr_ff;  ri_in = ri_ff;
      ovf_in = ovf_ff; dz_in = dz_ff;
      wr_ovf = cmd.from_div ? div_ovf : mul_ovf;
      if (cmd.load) begin
         xr_in = a_re; xi_in = a_im; yr_in = b_re; yi_in = b_im;
         rr_in = '0;   ri_in = '0;
         ovf_in = 1'b0; dz_in = 1'b0;
      end
      if (cmd.pow_init) begin
         yr_in = xr_ff; yi_in = xi_ff;
         rr_in = xr_ff; ri_in = xi_ff;
         if (cmd.pow_neg) begin
            xr_in = ONE_VAL; xi_in = '0;
         end
      end
      if (cmd.set_one) begin
         rr_in = ONE_VAL; ri_in = '0;
      end
      if (cmd.addsub_we) begin
         rr_in  = as_re_val; ri_in = as_im_val;
         ovf_in = ovf_ff | as_re_ovf | as_im_ovf;
      end
      if (cmd.wr_re) begin
         rr_in  = cmd.from_div ? div_val : mul_val;
         ovf_in = ovf_ff | wr_ovf;
      end
      if (cmd.wr_im) begin
         ri_in  = cmd.from_div ? div_val : mul_val;
         ovf_in = ovf_ff | wr_ovf;
      end
      if (cmd.x_from_res) begin
         xr_in = rr_ff; xi_in = ri_ff;
      end
      if (cmd.y_from_res) begin
         yr_in = rr_ff; yi_in = ri_ff;
      end
      if (cmd.set_dz) begin
         dz_in = 1'b1;
      end
   end

   // Divider registers
   always_comb begin
      den_in = cmd.den_we ? acc_ff[DEN_W-1:0] : den_ff;
      rem_in = rem_ff; dsh_in = dsh_ff; q_in = q_ff; big_in = big_ff; neg_in = neg_ff;
      if (cmd.div_init) begin
         neg_in = acc_ff[ACC_W-1];
         dsh_in = {acc_abs[DEN_W-1:0], FRAC_BITS'(0)};
         rem_in = '0;
         q_in   = '0;
         big_in = 1'b0;
      end else if (cmd.div_step) begin
         rem_in = dge ? dsub[DEN_W-1:0] : dtry[DEN_W-1:0];
         dsh_in = {dsh_ff[DSH_W-2:0], 1'b0};
         q_in   = {q_ff[Q_W-2:0], dge};
         big_in = big_ff | q_ff[Q_W-1];
      end
   end

   // Output register
   always_comb begin
      ore_in = ore_ff; oim_in = oim_ff; ost_in = ost_ff; ov_in = ov_ff;
      if (rsp_tready) begin
         ov_in = 1'b0;
      end
      if (cmd.out_load) begin
         ov_in  = 1'b1;
         ore_in = dz_ff ? '0 : rr_ff;
         oim_in = dz_ff ? '0 : ri_ff;
         ost_in = dz_ff ? STAT_DZ : (ovf_ff ? STAT_OVF : STAT_OK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff  <= 1'b0;
         ovf_ff <= 1'b0;
         dz_ff  <= 1'b0;
      end else begin
         ov_ff  <= ov_in;
         ovf_ff <= ovf_in;
         dz_ff  <= dz_in;
      end
   end

   always_ff @(posedge clock) begin
      xr_ff   <= xr_in;  xi_ff <= xi_in;  yr_ff <= yr_in;  yi_ff <= yi_in;
      rr_ff   <= rr_in;  ri_ff <= ri_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in; dsh_ff <= dsh_in; q_ff <= q_in;
      big_ff  <= big_in; neg_ff <= neg_in;
      ore_ff  <= ore_in; oim_ff <= oim_in; ost_ff <= ost_in;
   end

   assign stat.acc_zero = (acc_ff == '0);
   assign stat.out_busy = ov_ff && !rsp_tready;
   assign rsp_tvalid    = ov_ff;
   assign rsp_tdata     = {oim_ff, ore_ff};
   assign rsp_tuser     = {(RSP_USER_W-STAT_W)'(0), ost_ff};

endmodule

>>> design/cau_ctrl.sv
module cau_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cau_pkg::MODE_W-1:0]    mode,
   input  logic [cau_pkg::EXP_W-1:0]     exponent,
   input  cau_pkg::cau_stat_type         stat,
   output cau_pkg::cau_cmd_type          cmd
);
   import cau_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_ADDSUB = 5'd1;
   localparam logic [4:0] S_POWI   = 5'd2;
   localparam logic [4:0] S_MCHK   = 5'd3;
   localparam logic [4:0] S_M0     = 5'd4;
   localparam logic [4:0] S_M1     = 5'd5;
   localparam logic [4:0] S_M2     = 5'd6;
   localparam logic [4:0] S_M3     = 5'd7;
   localparam logic [4:0] S_M4     = 5'd8;
   localparam logic [4:0] S_M5     = 5'd9;
   localparam logic [4:0] S_D0     = 5'd10;
   localparam logic [4:0] S_D1     = 5'd11;
   localparam logic [4:0] S_D2     = 5'd12;
   localparam logic [4:0] S_D3     = 5'd13;
   localparam logic [4:0] S_N0     = 5'd14;
   localparam logic [4:0] S_N1     = 5'd15;
   localparam logic [4:0] S_N2     = 5'd16;
   localparam logic [4:0] S_N3     = 5'd17;
   localparam logic [4:0] S_DIV    = 5'd18;
   localparam logic [4:0] S_DFIN   = 5'd19;
   localparam logic [4:0] S_RCP    = 5'd20;
   localparam logic [4:0] S_DONE   = 5'd21;

   logic [4:0]        state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [EXP_W-1:0]  exp_ff, exp_in;
   logic [PCNT_W-1:0] pcnt_ff, pcnt_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              part_ff, part_in, recip_ff, recip_in;
   logic              e_neg;
   logic [EXP_W-1:0]  e_abs, e_mag;

   // Clamped exponent magnitude
   always_comb begin
      e_neg = exp_ff[EXP_W-1];
      e_abs = e_neg ? -exp_ff : exp_ff;
      e_mag = (e_abs > EXP_W'(MAX_POWER)) ? EXP_W'(MAX_POWER) : e_abs;
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      exp_in     = exp_ff;
      pcnt_in    = pcnt_ff;
      dcnt_in    = dcnt_ff;
      part_in    = part_ff;
      recip_in   = recip_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               mode_in  = mode;
               exp_in   = exponent;
               part_in  = 1'b0;
               recip_in = 1'b0;
               unique case (mode)
                  MODE_ADD, MODE_SUB: state_in = S_ADDSUB;
                  MODE_MUL:           state_in = S_M0;
                  MODE_DIV:           state_in = S_D0;
                  MODE_POW:           state_in = S_POWI;
                  default:            state_in = S_DONE;
               endcase
            end
         end
         S_ADDSUB: begin
            cmd.addsub_we  = 1'b1;
            cmd.addsub_sub = (mode_ff == MODE_SUB);
            state_in       = S_DONE;
         end
         S_POWI: begin
            if (e_mag == '0) begin
               cmd.set_one = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.pow_init = 1'b1;
               cmd.pow_neg  = e_neg;
               pcnt_in      = PCNT_W'(e_mag - EXP_W'(1));
               recip_in     = e_neg;
               state_in     = e_neg ? S_D0 : S_MCHK;
            end
         end
         S_MCHK: begin
            cmd.x_from_res = 1'b1;
            if (pcnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               pcnt_in  = pcnt_ff - PCNT_W'(1);
               state_in = S_M0;
            end
         end
         // Complex multiply: four products through one multiplier
         S_M0: begin
            cmd.mul_sel = MUL_XR_YR;
            state_in    = S_M1;
         end
         S_M1: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_XI_YI;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.acc_op  = ACC_SUB;
            cmd.mul_sel = MUL_XR_YI;
            state_in    = S_M3;
         end
         S_M3: begin
            cmd.wr_re   = 1'b1;
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_XI_YR;
            state_in    = S_M4;
         end
         S_M4: begin
            cmd.acc_op = ACC_ADD;
            state_in   = S_M5;
         end
         S_M5: begin
            cmd.wr_im = 1'b1;
            state_in  = (mode_ff == MODE_POW) ? S_MCHK : S_DONE;
         end
         // Divisor |y|^2
         S_D0: begin
            cmd.mul_sel = MUL_YR_YR;
            state_in    = S_D1;
         end
         S_D1: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_YI_YI;
            state_in    = S_D2;
         end
         S_D2: begin
            cmd.acc_op = ACC_ADD;
            state_in   = S_D3;
         end
         S_D3: begin
            cmd.den_we = 1'b1;
            if (stat.acc_zero) begin
               cmd.set_dz = 1'b1;
               state_in   = S_DONE;
            end else begin
               part_in  = 1'b0;
               state_in = S_N0;
            end
         end
         // Numerator of the real or imaginary part
         S_N0: begin
            cmd.mul_sel = part_ff ? MUL_XI_YR : MUL_XR_YR;
            state_in    = S_N1;
         end
         S_N1: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = part_ff ? MUL_XR_YI : MUL_XI_YI;
            state_in    = S_N2;
         end
         S_N2: begin
            cmd.acc_op = part_ff ? ACC_SUB : ACC_ADD;
            state_in   = S_N3;
         end
         S_N3: begin
            cmd.div_init = 1'b1;
            dcnt_in      = DCNT_W'(DIV_STEPS);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff - DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(1)) begin
               state_in = S_DFIN;
            end
         end
         S_DFIN: begin
            cmd.from_div = 1'b1;
            cmd.wr_re    = !part_ff;
            cmd.wr_im    = part_ff;
            if (!part_ff) begin
               part_in  = 1'b1;
               state_in = S_N0;
            end else begin
               state_in = recip_ff ? S_RCP : S_DONE;
            end
         end
         S_RCP: begin
            cmd.y_from_res = 1'b1;
            state_in       = S_MCHK;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      exp_ff   <= exp_in;
      pcnt_ff  <= pcnt_in;
      dcnt_ff  <= dcnt_in;
      part_ff  <= part_in;
      recip_ff <= recip_in;
   end

endmodule

>>> design/complex_arith_unit.sv
// Divide runs two 80-step restoring divisions, one per result part; a power
// with positive exponent n repeats the complex multiply n-1 times, and a
// negative one first forms the reciprocal by division; exponent zero gives one.
// One item at a time; a finished result waits in the output register while the
// next item is accepted. Throughput set by the shared multiplier and divider.
// Synchronous active-high reset returns the controller to idle with no output.
module complex_arith_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // a_re, a_im, b_re, b_im, exponent
   input  logic [cau_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic [cau_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // res_re, res_im
   output logic [cau_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status
   output logic [cau_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import cau_pkg::*;

   cau_cmd_type  cmd;
   cau_stat_type stat;

   cau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .mode       (req_tuser[MODE_W-1:0]),
      .exponent   (req_tdata[4*DW +: EXP_W]),
      .stat       (stat),
      .cmd        (cmd)
   );

   cau_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .a_re       (req_tdata[0*DW +: DW]),
      .a_im       (req_tdata[1*DW +: DW]),
      .b_re       (req_tdata[2*DW +: DW]),
      .b_im       (req_tdata[3*DW +: DW]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> design/cau_checker.sv
`include "complex_arith_unit_macros.svh"

module cau_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cau_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [cau_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import cau_pkg::*;

   // Input side is closed in the cycle after each transfer
   `CAU_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready, "ready after transfer")
   // Status never carries the unused code
   `CAU_ASSERT_SAME(a_status_code, rsp_tvalid, rsp_tuser[STAT_W-1:0] != STAT_RSVD, "bad status")
   // Divide by zero returns zero
   `CAU_ASSERT_SAME(a_dz_zero, rsp_tvalid && rsp_tuser[STAT_W-1:0] == STAT_DZ, rsp_tdata == '0, "dz data")
   // Stalled result holds
   `CAU_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp drop")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import cau_pkg::*;

   localparam int CLK_HALF   = 5;
   localparam int RESET_CYC  = 11;
   localparam int RAND_ITEMS = 800;
   // no transfer on either side for this long ends the run
   localparam int STALL_LIMIT = 5000;
   // slowest item (negative power) plus margin
   localparam int DRAIN_CYC  = 400;

   typedef logic signed [DW-1:0] fix_type;
   typedef struct {
      fix_type re;
      fix_type im;
   } cplx_type;

   typedef struct {
      logic [MODE_W-1:0] mode;
      fix_type           a_re, a_im, b_re, b_im;
      logic [EXP_W-1:0]  expo;
      bit                fixed;
      fix_type           x_re, x_im;
      logic [STAT_W-1:0] x_st;
   } op_row_type;

   typedef struct {
      fix_type           re, im;
      logic [STAT_W-1:0] st;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   op_row_type op_rows[$];
   answer_type pending_answers[$];
   int      errors = 0;
   int      quiet_cycles = 0;
   int      sink_hold = 0;
   bit      sink_calm = 1'b0;

   always #CLK_HALF clock = ~clock;

   complex_arith_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---------------- fixed-point complex math ----------------

   // exact p +/- q as sign and magnitude
   function automatic void wide_add(input longint p, input longint q, input bit sub,
                                    output bit neg, output logic [63:0] mag);
      logic [63:0] u;
      u = sub ? 64'(p) - 64'(q) : 64'(p) + 64'(q);
      if (u <= 64'h8000_0000_0000_0000) begin
         neg = 1'b0;
         mag = u;
      end else begin
         neg = 1'b1;
         mag = 64'd0 - u;
      end
   endfunction

   function automatic fix_type clip(input bit neg, input logic [63:0] m, inout bit ovf);
      if (neg) begin
         if (m > 64'h8000_0000) begin
            ovf = 1'b1;
            return fix_type'(MIN_VAL);
         end
         return fix_type'(64'd0 - m);
      end
      if (m > 64'h7FFF_FFFF) begin
         ovf = 1'b1;
         return fix_type'(MAX_VAL);
      end
      return fix_type'(m);
   endfunction

   function automatic logic [63:0] scale_round(input logic [63:0] m);
      return (m >> FRAC_BITS) + ((m >> (FRAC_BITS - 1)) & 64'd1);
   endfunction

   function automatic fix_type sat_sum(input fix_type x, input fix_type y, input bit sub,
                                       inout bit ovf);
      longint s;
      s = sub ? longint'(x) - longint'(y) : longint'(x) + longint'(y);
      if (s > longint'(fix_type'(MAX_VAL))) begin
         ovf = 1'b1;
         return fix_type'(MAX_VAL);
      end
      if (s < longint'(fix_type'(MIN_VAL))) begin
         ovf = 1'b1;
         return fix_type'(MIN_VAL);
      end
      return fix_type'(s);
   endfunction

   function automatic cplx_type cplx_mul(input cplx_type x, input cplx_type y,
                                         inout bit ovf);
      cplx_type r;
      bit neg;
      logic [63:0] m;
      wide_add(longint'(x.re) * y.re, longint'(x.im) * y.im, 1'b1, neg, m);
      r.re = clip(neg, scale_round(m), ovf);
      wide_add(longint'(x.re) * y.im, longint'(x.im) * y.re, 1'b0, neg, m);
      r.im = clip(neg, scale_round(m), ovf);
      return r;
   endfunction

   // rounded (mag << FRAC_BITS) / den, huge quotients capped at 2^40
   function automatic logic [63:0] frac_quotient(input logic [63:0] mag,
                                                 input logic [63:0] den);
      logic [63:0] rem, q;
      bit big, b;
      rem = '0;
      q = '0;
      big = 1'b0;
      for (int i = 63 + FRAC_BITS; i >= 0; i--) begin
         b = (i >= FRAC_BITS) ? mag[i - FRAC_BITS] : 1'b0;
         rem = {rem[62:0], b};
         if ((q >> 40) != 0) big = 1'b1;
         if (!big) q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            if (!big) q[0] = 1'b1;
         end
      end
      if (big) return 64'd1 << 40;
      if (rem >= den - rem) q = q + 1;
      return q;
   endfunction

   function automatic cplx_type cplx_div(input cplx_type x, input cplx_type y,
                                         inout bit ovf, inout bit dz);
      cplx_type r;
      bit neg;
      logic [63:0] m, den;
      r.re = 0;
      r.im = 0;
      den = 64'(longint'(y.re) * y.re) + 64'(longint'(y.im) * y.im);
      if (den == 0) begin
         dz = 1'b1;
         return r;
      end
      wide_add(longint'(x.re) * y.re, longint'(x.im) * y.im, 1'b0, neg, m);
      r.re = clip(neg, frac_quotient(m, den), ovf);
      wide_add(longint'(x.im) * y.re, longint'(x.re) * y.im, 1'b1, neg, m);
      r.im = clip(neg, frac_quotient(m, den), ovf);
      return r;
   endfunction

   function automatic cplx_type cplx_pow(input cplx_type base, input int e,
                                         inout bit ovf, inout bit dz);
      cplx_type one, acc;
      int n;
      one.re = fix_type'(ONE_VAL);
      one.im = 0;
      if (e > MAX_POWER) e = MAX_POWER;
      if (e < -MAX_POWER) e = -MAX_POWER;
      if (e == 0) return one;
      if (e < 0) begin
         if (base.re == 0 && base.im == 0) begin
            dz = 1'b1;
            acc.re = 0;
            acc.im = 0;
            return acc;
         end
         base = cplx_div(one, base, ovf, dz);
         n = -e;
      end else begin
         n = e;
      end
      acc = base;
      for (int i = 2; i <= n; i++) acc = cplx_mul(acc, base, ovf);
      return acc;
   endfunction

   function automatic answer_type compute_answer(input op_row_type r);
      answer_type ans;
      cplx_type a, b, res;
      bit ovf, dz;
      a.re = r.a_re;
      a.im = r.a_im;
      b.re = r.b_re;
      b.im = r.b_im;
      res.re = 0;
      res.im = 0;
      ovf = 1'b0;
      dz = 1'b0;
      case (r.mode)
         MODE_ADD, MODE_SUB: begin
            res.re = sat_sum(a.re, b.re, r.mode == MODE_SUB, ovf);
            res.im = sat_sum(a.im, b.im, r.mode == MODE_SUB, ovf);
         end
         MODE_MUL: res = cplx_mul(a, b, ovf);
         MODE_DIV: res = cplx_div(a, b, ovf, dz);
         MODE_POW: res = cplx_pow(a, int'($signed(r.expo)), ovf, dz);
         default: ;
      endcase
      if (dz) begin
         res.re = 0;
         res.im = 0;
      end
      ans.re = res.re;
      ans.im = res.im;
      ans.st = dz ? STAT_DZ : (ovf ? STAT_OVF : STAT_OK);
      return ans;
   endfunction

   // ---------------- stimulus ----------------

   function automatic void add_row(input logic [MODE_W-1:0] mode, input fix_type ar,
                                   input fix_type ai, input fix_type br,
                                   input fix_type bi, input int e,
                                   input bit fixed = 1'b0,
                                   input fix_type xr = 0, input fix_type xi = 0,
                                   input logic [STAT_W-1:0] xs = STAT_OK);
      op_row_type r;
      r.mode = mode;
      r.a_re = ar;
      r.a_im = ai;
      r.b_re = br;
      r.b_im = bi;
      r.expo = EXP_W'(e);
      r.fixed = fixed;
      r.x_re = xr;
      r.x_im = xi;
      r.x_st = xs;
      op_rows.push_back(r);
   endfunction

   function automatic fix_type pick_value(input bit near_one);
      int sel;
      sel = $urandom_range(0, 9);
      if (near_one || sel < 4)
         return fix_type'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      if (sel < 7) return fix_type'($urandom);
      if (sel < 8) return fix_type'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
      case ($urandom_range(0, 4))
         0: return fix_type'(MIN_VAL);
         1: return fix_type'(MAX_VAL);
         2: return fix_type'(ONE_VAL);
         3: return -fix_type'(ONE_VAL);
         default: return 0;
      endcase
   endfunction

   function automatic int gap_len();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_row(input op_row_type r, input bit calm);
      answer_type ans;
      int gap;
      gap = calm ? 0 : gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, r.expo, r.b_im, r.b_re, r.a_im, r.a_re};
      req_tuser <= REQ_USER_W'(r.mode);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (r.fixed) begin
         ans.re = r.x_re;
         ans.im = r.x_im;
         ans.st = r.x_st;
      end else begin
         ans = compute_answer(r);
      end
      pending_answers.push_back(ans);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
   endtask

   // ---------------- response side ----------------

   // mostly short stalls, now and then a long one
   always @(posedge clock) begin
      if (reset || sink_calm) begin
         rsp_tready <= 1'b1;
         sink_hold  <= 0;
      end else if (sink_hold > 0) begin
         rsp_tready <= 1'b0;
         sink_hold  <= sink_hold - 1;
      end else begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: rsp_tready <= 1'b0;
            5: begin
               rsp_tready <= 1'b0;
               sink_hold  <= $urandom_range(10, 40);
            end
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_tdata[31:0], 32'h0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[31:0] !== want.re)
               report_mismatch("res_re", rsp_tdata[31:0], want.re);
            if (rsp_tdata[63:32] !== want.im)
               report_mismatch("res_im", rsp_tdata[63:32], want.im);
            if (rsp_tuser[STAT_W-1:0] !== want.st)
               report_mismatch("status", 32'(rsp_tuser[STAT_W-1:0]), 32'(want.st));
         end
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      op_row_type r;
      fix_type one;
      bit near;
      one = fix_type'(ONE_VAL);

      // directed cases
      add_row(MODE_ADD, MAX_VAL, MAX_VAL, 1, 1, 0, 1, MAX_VAL, MAX_VAL, STAT_OVF);
      add_row(MODE_SUB, MIN_VAL, MIN_VAL, 1, 1, 0, 1, MIN_VAL, MIN_VAL, STAT_OVF);
      add_row(MODE_ADD, 0, 0, 0, 0, 0, 1, 0, 0, STAT_OK);
      add_row(MODE_ADD, 5, -7, 9, 11, -32);
      add_row(MODE_MUL, one, 0, one, 0, 0);
      add_row(MODE_MUL, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, 0);
      add_row(MODE_MUL, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL, 0);
      add_row(MODE_MUL, 1, 3, one / 2, -(one / 2), 0);
      add_row(MODE_DIV, 123, 456, 0, 0, 0, 1, 0, 0, STAT_DZ);
      add_row(MODE_DIV, MAX_VAL, MIN_VAL, 1, 0, 0);
      add_row(MODE_DIV, 3 * one, 4 * one, one, 2 * one, 0);
      add_row(MODE_DIV, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, 0);
      add_row(MODE_POW, 0, 0, 0, 0, 0, 1, one, 0, STAT_OK);
      add_row(MODE_POW, MAX_VAL, MIN_VAL, 0, 0, 0, 1, one, 0, STAT_OK);
      add_row(MODE_POW, 0, 0, 0, 0, -3, 1, 0, 0, STAT_DZ);
      add_row(MODE_POW, one + 100, 50, 0, 0, 31);
      add_row(MODE_POW, one - 300, -20, 0, 0, -32);
      add_row(MODE_POW, MIN_VAL, MAX_VAL, 0, 0, 1);
      add_row(MODE_POW, 0, one, 0, 0, -1);
      add_row(MODE_POW, 0, one, 0, 0, 16);
      add_row(MODE_POW, 2 * one, 0, 0, 0, 16);
      add_row(3'd5, MAX_VAL, 1, 2, 3, 4, 1, 0, 0, STAT_OK);
      add_row(3'd6, MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL, -1, 1, 0, 0, STAT_OK);
      add_row(3'd7, -1, -1, -1, -1, 31, 1, 0, 0, STAT_OK);

      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (op_rows[i]) send_row(op_rows[i], 1'b0);

      // random items
      for (int n = 0; n < RAND_ITEMS; n++) begin
         // hold off until the unit has drained everything
         if (n == RAND_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_answers.size() != 0) @(posedge clock);
         end
         // a stretch with both sides running flat out
         sink_calm <= (n >= 200 && n < 260);
         r.mode = ($urandom_range(0, 19) == 0) ? MODE_W'($urandom_range(5, 7))
                                                : MODE_W'($urandom_range(0, 4));
         near = (r.mode == MODE_POW) && ($urandom_range(0, 3) != 0);
         r.a_re = pick_value(near);
         r.a_im = pick_value(near);
         r.b_re = pick_value(1'b0);
         r.b_im = pick_value(1'b0);
         if ($urandom_range(0, 19) == 0) begin
            r.b_re = 0;
            r.b_im = 0;
         end
         if (r.mode == MODE_POW && $urandom_range(0, 19) == 0) begin
            r.a_re = 0;
            r.a_im = 0;
         end
         r.expo = ($urandom_range(0, 4) == 0) ? EXP_W'($urandom)
                                              : EXP_W'($urandom_range(0, 32) - 16);
         r.fixed = 1'b0;
         send_row(r, n >= 200 && n < 260);
      end
      req_tvalid <= 1'b0;
      sink_calm <= 1'b0;

      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
